/* design/route_lookup_forward_decision_unit_macros.svh */
// ----------------------------------------------------------------------------
// Route lookup forward decision unit: assertion macros
// Concurrent assertion shorthands on the clock and reset of the unit.
// ----------------------------------------------------------------------------
`ifndef ROUTE_LOOKUP_FORWARD_DECISION_UNIT_MACROS_SVH
`define ROUTE_LOOKUP_FORWARD_DECISION_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define RLFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define RLFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/rlfd_pkg.sv */
// ----------------------------------------------------------------------------
// Route lookup forward decision package
// Request and response types, action codes and the sequencer microcode.
// ----------------------------------------------------------------------------
package rlfd_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int PORT_COUNT            = 4;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   localparam logic [1:0] ACT_FORWARD = 2'd0;
   localparam logic [1:0] ACT_UNREACH = 2'd1;
   localparam logic [1:0] ACT_EXPIRED = 2'd2;
   localparam logic [1:0] ACT_WRITTEN = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  entry_index;
      logic [31:0] entry_dest;
      logic [31:0] entry_mask;
      logic [31:0] entry_next_hop;
      logic [1:0]  entry_port;
      logic        entry_valid;
      logic [31:0] dst_addr;
      logic [7:0]  ttl_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  out_port;
      logic [31:0] next_hop;
      logic [3:0]  matched_index;
      logic [7:0]  ttl_out;
   } rsp_type;

   // One table row as held in the route memory
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] next_hop;
      logic [1:0]  port;
   } route_type;

   // Sequencer steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
   localparam logic [STEP_W-1:0] STEP_WRITE    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DRAIN    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd5;

   // Jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd0;
   localparam logic [COND_W-1:0] COND_NO_REQ    = 3'd1;
   localparam logic [COND_W-1:0] COND_LOOKUP    = 3'd2;
   localparam logic [COND_W-1:0] COND_SCAN_MORE = 3'd3;
   localparam logic [COND_W-1:0] COND_RSP_BUSY  = 3'd4;

   typedef struct packed {
      logic take_req;
      logic clr_best;
      logic wr_en;
      logic rd_issue;
      logic load_rsp;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic lookup;
      logic scan_more;
      logic rsp_busy;
   } status_type;

   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jmp_t;
      logic [STEP_W-1:0] jmp_f;
      ctrl_type          ctrl;
   } ucode_type;

   function automatic ucode_type uword(
      input logic [COND_W-1:0] cond,
      input logic [STEP_W-1:0] jmp_t,
      input logic [STEP_W-1:0] jmp_f,
      input logic              take_req,
      input logic              clr_best,
      input logic              wr_en,
      input logic              rd_issue,
      input logic              load_rsp
   );
      ucode_type w;
      w.cond          = cond;
      w.jmp_t         = jmp_t;
      w.jmp_f         = jmp_f;
      w.ctrl.take_req = take_req;
      w.ctrl.clr_best = clr_best;
      w.ctrl.wr_en    = wr_en;
      w.ctrl.rd_issue = rd_issue;
      w.ctrl.load_rsp = load_rsp;
      return w;
   endfunction

   // Control store: cond, jump if true, jump if false, then
   // take_req, clr_best, wr_en, rd_issue, load_rsp
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         STEP_WAIT:
            w = uword(COND_NO_REQ, STEP_WAIT, STEP_DISPATCH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
         STEP_DISPATCH:
            w = uword(COND_LOOKUP, STEP_SCAN, STEP_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
         STEP_WRITE:
            w = uword(COND_ALWAYS, STEP_EMIT, STEP_EMIT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
         STEP_SCAN:
            w = uword(COND_SCAN_MORE, STEP_SCAN, STEP_DRAIN, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
         STEP_DRAIN:
            w = uword(COND_ALWAYS, STEP_EMIT, STEP_EMIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
         STEP_EMIT:
            w = uword(COND_RSP_BUSY, STEP_EMIT, STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         default:
            w = uword(COND_ALWAYS, STEP_WAIT, STEP_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

/* design/rlfd_ram.sv */
// ----------------------------------------------------------------------------
// Route lookup generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rlfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rlfd_seq.sv */
// ----------------------------------------------------------------------------
// Route lookup sequencer
// Step counter over the microcode store, with conditional jumps.
// ----------------------------------------------------------------------------
module rlfd_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  rlfd_pkg::status_type status,
   output rlfd_pkg::ctrl_type   ctrl
);

   logic [rlfd_pkg::STEP_W-1:0] step_ff;
   logic [rlfd_pkg::STEP_W-1:0] step_in;
   rlfd_pkg::ucode_type         word;
   logic                        taken;

   always_comb begin
      word = rlfd_pkg::ucode(step_ff);
      case (word.cond)
         rlfd_pkg::COND_ALWAYS:    taken = 1'b1;
         rlfd_pkg::COND_NO_REQ:    taken = !status.req_valid;
         rlfd_pkg::COND_LOOKUP:    taken = status.lookup;
         rlfd_pkg::COND_SCAN_MORE: taken = status.scan_more;
         rlfd_pkg::COND_RSP_BUSY:  taken = status.rsp_busy;
         default:                  taken = 1'b1;
      endcase
      step_in = taken ? word.jmp_t : word.jmp_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rlfd_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = word.ctrl;

endmodule

/* design/route_lookup_forward_decision_unit.sv */
// ----------------------------------------------------------------------------
// Route lookup forward decision unit
// Longest prefix match over a table of IPv4 routes, with TTL decrement.
//
//   channel   direction  payload          handshake
//   req_      in         rlfd_pkg::req_type   req_valid / req_stall
//   rsp_      out        rlfd_pkg::rsp_type   rsp_valid / rsp_stall
//
// A lookup reads one route from the table memory and compares it per cycle,
// scanning every slot through the single read port before it answers; a write
// passes through the wait, dispatch, write and emit steps.
// Reset clears the valid bits at once; there is no clearing pass.
// The response register holds a stalled response while the next request is
// taken; the sequencer waits only to load a new response over a stalled one.
// ----------------------------------------------------------------------------
module route_lookup_forward_decision_unit #(
   parameter int TABLE_ENTRIES = rlfd_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlfd_pkg::rsp_type rsp_data
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ROUTE_W = $bits(rlfd_pkg::route_type);

   rlfd_pkg::ctrl_type   ctrl;
   rlfd_pkg::status_type status;

   // Latched request
   rlfd_pkg::req_type req_ff;
   logic              req_take;

   // Table valid bits, one per slot
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;

   // Write path
   logic             wr_ok;
   logic [IDX_W-1:0] wr_addr;
   rlfd_pkg::route_type wr_route;

   // Scan path
   logic [IDX_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    scan_in;
   logic                rd_pend_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [ROUTE_W-1:0]  rd_data;
   rlfd_pkg::route_type rd_route;
   logic                hit;

   // Best match so far
   logic                found_ff;
   logic                found_in;
   logic [31:0]         best_mask_ff;
   logic [31:0]         best_mask_in;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [IDX_W-1:0]    best_idx_in;
   logic [1:0]          best_port_ff;
   logic [1:0]          best_port_in;
   logic [31:0]         best_hop_ff;
   logic [31:0]         best_hop_in;

   // Response register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rlfd_pkg::rsp_type rsp_ff;
   rlfd_pkg::rsp_type rsp_in;
   logic              rsp_busy;
   logic              rsp_load;
   logic [7:0]        ttl_dec;

   // ---- sequencer ---------------------------------------------------------
   assign rsp_busy         = rsp_valid_ff && rsp_stall;
   assign status.req_valid = req_valid;
   assign status.lookup    = (req_ff.cmd == rlfd_pkg::CMD_LOOKUP);
   assign status.scan_more = (scan_ff != IDX_W'(TABLE_ENTRIES - 1));
   assign status.rsp_busy  = rsp_busy;

   rlfd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // ---- request intake ----------------------------------------------------
   // Take a request only in the wait step.
   assign req_stall = !ctrl.take_req;
   assign req_take  = req_valid && ctrl.take_req;

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   // ---- table write -------------------------------------------------------
   // Drop writes to a slot beyond the table or to a port that does not exist.
   assign wr_ok = ctrl.wr_en
                  && (32'(req_ff.entry_index) < TABLE_ENTRIES)
                  && (32'(req_ff.entry_port) < rlfd_pkg::PORT_COUNT);
   assign wr_addr           = IDX_W'(req_ff.entry_index);
   assign wr_route.dest     = req_ff.entry_dest;
   assign wr_route.mask     = req_ff.entry_mask;
   assign wr_route.next_hop = req_ff.entry_next_hop;
   assign wr_route.port     = req_ff.entry_port;

   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_addr] = req_ff.entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   rlfd_ram #(
      .WIDTH (ROUTE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_route),
      .rd_en   (ctrl.rd_issue),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // ---- scan --------------------------------------------------------------
   // Issue one read per scan step; compare the row in the next cycle.
   always_comb begin
      scan_in = scan_ff;
      if (ctrl.clr_best) begin
         scan_in = '0;
      end else if (ctrl.rd_issue) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         scan_ff    <= scan_in;
         rd_pend_ff <= ctrl.rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff;
   end

   assign rd_route = rlfd_pkg::route_type'(rd_data);

   // A later slot wins a tie on the mask; a zero mask matches any address.
   assign hit = rd_pend_ff
                && valid_ff[rd_idx_ff]
                && (((rd_route.dest ^ req_ff.dst_addr) & rd_route.mask) == 32'd0)
                && (best_mask_ff <= rd_route.mask);

   always_comb begin
      found_in     = found_ff;
      best_mask_in = best_mask_ff;
      best_idx_in  = best_idx_ff;
      best_port_in = best_port_ff;
      best_hop_in  = best_hop_ff;
      if (ctrl.clr_best) begin
         found_in     = 1'b0;
         best_mask_in = '0;
      end else if (hit) begin
         found_in     = 1'b1;
         best_mask_in = rd_route.mask;
         best_idx_in  = rd_idx_ff;
         best_port_in = rd_route.port;
         best_hop_in  = rd_route.next_hop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_mask_ff <= best_mask_in;
      best_idx_ff  <= best_idx_in;
      best_port_ff <= best_port_in;
      best_hop_ff  <= best_hop_in;
   end

   // ---- response ----------------------------------------------------------
   assign ttl_dec  = req_ff.ttl_in - 8'd1;
   assign rsp_load = ctrl.load_rsp && !rsp_busy;

   always_comb begin
      rsp_in = '0;
      if (req_ff.cmd == rlfd_pkg::CMD_WRITE) begin
         rsp_in.action = rlfd_pkg::ACT_WRITTEN;
      end else if (!found_ff) begin
         // No route: report unreachable ahead of any TTL check.
         rsp_in.action  = rlfd_pkg::ACT_UNREACH;
         rsp_in.ttl_out = ttl_dec;
      end else begin
         rsp_in.action        = (ttl_dec == 8'd0) ? rlfd_pkg::ACT_EXPIRED
                                                  : rlfd_pkg::ACT_FORWARD;
         rsp_in.out_port      = best_port_ff;
         rsp_in.next_hop      = best_hop_ff;
         rsp_in.matched_index = 4'(best_idx_ff);
         rsp_in.ttl_out       = ttl_dec;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/rlfd_checker.sv */
// ----------------------------------------------------------------------------
// Route lookup forward decision checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "route_lookup_forward_decision_unit_macros.svh"

module rlfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rlfd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rlfd_pkg::rsp_type rsp_data
);

   logic rsp_is_write;
   logic rsp_is_unreach;
   logic rsp_is_route;
   logic rsp_no_route;
   logic rsp_expired;
   logic rsp_ttl_zero;

   assign rsp_is_write   = rsp_valid && (rsp_data.action == rlfd_pkg::ACT_WRITTEN);
   assign rsp_is_unreach = rsp_valid && (rsp_data.action == rlfd_pkg::ACT_UNREACH);
   assign rsp_is_route   = rsp_valid && ((rsp_data.action == rlfd_pkg::ACT_FORWARD)
                                         || (rsp_data.action == rlfd_pkg::ACT_EXPIRED));
   assign rsp_no_route   = (rsp_data.out_port == 2'd0) && (rsp_data.next_hop == 32'd0)
                           && (rsp_data.matched_index == 4'd0);
   assign rsp_expired    = (rsp_data.action == rlfd_pkg::ACT_EXPIRED);
   assign rsp_ttl_zero   = (rsp_data.ttl_out == 8'd0);

   // A write answer carries nothing but its action code.
   `RLFD_ASSERT_NOW(a_write_zero, rsp_is_write, rsp_no_route && rsp_ttl_zero, "write response carries route data")

   // An unreachable answer names no route.
   `RLFD_ASSERT_NOW(a_unreach_zero, rsp_is_unreach, rsp_no_route, "unreachable response names a route")

   // Expiry follows the decremented TTL exactly.
   `RLFD_ASSERT_NOW(a_expiry, rsp_is_route, rsp_expired == rsp_ttl_zero, "expiry disagrees with TTL")

   // Hold a stalled response.
   `RLFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

   // Hold a stalled request.
   `RLFD_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data), "stalled request changed")

endmodule

bind route_lookup_forward_decision_unit rlfd_checker u_rlfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
